[design/swsf_pkg.sv]
// Package for the stack with search and filter block.
// Holds request/response types, command, compare-mode and status codes.
// No dependencies.
package swsf_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_EXISTS = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_LT = 2'd0,
		MODE_EQ = 2'd1,
		MODE_GT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_POP_EMPTY  = 2'd1,
		STAT_PUSH_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]              command;
		logic signed [VAL_W-1:0] operand_value;
		logic [1:0]              compare_mode;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] popped_value;
		logic                    found;
		logic [CNT_OUT_W-1:0]    entry_count;
		logic                    is_empty;
		logic [1:0]              status;
	} rsp_t;

endpackage

[design/swsf_stream_if.sv]
// Valid/ready stream interface carrying one request or response payload.
// Payload type is a parameter; types come from swsf_pkg.
interface swsf_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/swsf_mem.sv]
// Entry store: one write port, one read port, registered read data.
// Depends on swsf_pkg for the word width.
module swsf_mem #(
	parameter int DEPTH = swsf_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [swsf_pkg::VAL_W-1:0]    wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [swsf_pkg::VAL_W-1:0]    rdata
);

	logic [swsf_pkg::VAL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/swsf_ctrl.sv]
// Command sequencer: decodes a request, walks the entry store for exists and
// remove, compacts survivors in place, and holds the response until taken.
// Depends on swsf_pkg; drives swsf_mem.
module swsf_ctrl #(
	parameter int DEPTH = swsf_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  swsf_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output swsf_pkg::rsp_t                rsp,
	output logic                          mem_we,
	output logic [$clog2(DEPTH)-1:0]      mem_waddr,
	output logic [swsf_pkg::VAL_W-1:0]    mem_wdata,
	output logic                          mem_re,
	output logic [$clog2(DEPTH)-1:0]      mem_raddr,
	input  logic [swsf_pkg::VAL_W-1:0]    mem_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               rd_idx_q;
	logic [CW-1:0]               kept_q;
	logic [1:0]                  op_q;
	logic [1:0]                  mode_q;
	logic signed [swsf_pkg::VAL_W-1:0] val_q;
	logic signed [swsf_pkg::VAL_W-1:0] popped_q;
	logic                        found_q;
	logic [1:0]                  status_q;

	logic                        accept;
	logic                        full;
	logic                        empty;
	logic                        hit_eq;
	logic                        hit;
	logic                        keep;
	logic [CW-1:0]               count_m1;
	logic [CW+swsf_pkg::CNT_OUT_W-1:0] count_ext;

	assign accept   = req_valid && (state_q == ST_IDLE);
	assign req_ready = (state_q == ST_IDLE);
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign count_m1 = count_q - CW'(1);

	// compare the entry just read against the latched operand
	always_comb begin
		hit_eq = ($signed(mem_rdata) == val_q);
		case (mode_q)
			swsf_pkg::MODE_LT: hit = ($signed(mem_rdata) < val_q);
			swsf_pkg::MODE_EQ: hit = hit_eq;
			swsf_pkg::MODE_GT: hit = ($signed(mem_rdata) > val_q);
			default:           hit = 1'b0;
		endcase
		keep = !hit;
	end

	// write address (kept) always trails the read index, so no forwarding
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = kept_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = rd_idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.command)
						swsf_pkg::CMD_PUSH: begin
							mem_we    = !full;
							mem_waddr = count_q[AW-1:0];
							mem_wdata = req.operand_value;
						end
						swsf_pkg::CMD_POP: begin
							mem_re    = !empty;
							mem_raddr = count_m1[AW-1:0];
						end
						default: begin
							mem_re    = !empty;
							mem_raddr = '0;
						end
					endcase
				end
			end
			ST_SCAN: begin
				mem_re = (rd_idx_q != count_q);
				mem_we = (op_q == swsf_pkg::CMD_REMOVE) && keep;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			kept_q   <= '0;
			op_q     <= '0;
			mode_q   <= '0;
			val_q    <= '0;
			popped_q <= '0;
			found_q  <= 1'b0;
			status_q <= swsf_pkg::STAT_OK;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q     <= req.command;
						mode_q   <= req.compare_mode;
						val_q    <= req.operand_value;
						popped_q <= '0;
						found_q  <= 1'b0;
						status_q <= swsf_pkg::STAT_OK;
						case (req.command)
							swsf_pkg::CMD_PUSH: begin
								if (full) begin
									status_q <= swsf_pkg::STAT_PUSH_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_DONE;
							end
							swsf_pkg::CMD_POP: begin
								if (empty) begin
									status_q <= swsf_pkg::STAT_POP_EMPTY;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_POP_RD;
								end
							end
							default: begin
								rd_idx_q <= CW'(1);
								kept_q   <= '0;
								state_q  <= empty ? ST_DONE : ST_SCAN;
							end
						endcase
					end
				end
				ST_POP_RD: begin
					popped_q <= mem_rdata;
					count_q  <= count_m1;
					state_q  <= ST_DONE;
				end
				ST_SCAN: begin
					if (mem_re) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (op_q == swsf_pkg::CMD_EXISTS && hit_eq) begin
						found_q <= 1'b1;
					end
					if (mem_we) begin
						kept_q <= kept_q + CW'(1);
					end
					// last entry is being compared: no read left to issue
					if (rd_idx_q == count_q) begin
						if (op_q == swsf_pkg::CMD_REMOVE) begin
							count_q <= kept_q + CW'(keep);
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign count_ext = {{swsf_pkg::CNT_OUT_W{1'b0}}, count_q};

	always_comb begin
		rsp_valid         = (state_q == ST_DONE);
		rsp.popped_value  = popped_q;
		rsp.found         = found_q;
		rsp.entry_count   = count_ext[swsf_pkg::CNT_OUT_W-1:0];
		rsp.is_empty      = empty;
		rsp.status        = status_q;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_push_incr: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command == swsf_pkg::CMD_PUSH && !full)
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not grow the store");

	a_wr_trails_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && mem_we) |-> (kept_q < rd_idx_q))
		else $error("compaction write overtook the read index");

	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_SCAN))
		else $error("store written outside push or remove");

endmodule

[design/stack_with_search_and_filter_core.sv]
// Channel   Dir  Payload                                          Handshake
// in_ch     in   command, operand_value, compare_mode             valid/ready
// out_ch    out  popped_value, found, entry_count, is_empty,      valid/ready
//                status
// Push writes the store on acceptance; pop reads the top entry and latches it;
// exists and remove read one stored entry per cycle through the single read port.
// One request in flight; the next is taken while the previous response sits in
// the output register. arst_n clears count and control; entries need no clear.
// out_ch stall holds the response and backs up into in_ch.ready.
// Top level: instantiates swsf_ctrl and swsf_mem; uses swsf_pkg, swsf_stream_if.
module stack_with_search_and_filter_core #(
	parameter int DEPTH = swsf_pkg::DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	swsf_stream_if.sink           in_ch,
	swsf_stream_if.source         out_ch
);

	localparam int AW = $clog2(DEPTH);

	logic                       rsp_valid;
	logic                       rsp_ready;
	swsf_pkg::rsp_t             rsp;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [swsf_pkg::VAL_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	logic [swsf_pkg::VAL_W-1:0] mem_rdata;
	logic                       out_vld_q;
	swsf_pkg::rsp_t             out_data_q;

	swsf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_ch.valid),
		.req_ready (in_ch.ready),
		.req       (in_ch.data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	swsf_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register separates the sequencer from the downstream stall
	assign rsp_ready = !out_vld_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rsp_ready) begin
			out_vld_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ready && rsp_valid) begin
			out_data_q <= rsp;
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.data  = out_data_q;

endmodule

[tb/stack_with_search_and_filter_core_tb.sv]
// Testbench for stack_with_search_and_filter_core: push, pop, exists and remove requests
// are checked against a cycle-free predictor of the store, with random gaps and stalls.
// Depends on swsf_pkg, swsf_stream_if and the core RTL.
module stack_with_search_and_filter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swsf_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	// compare code with no match rule: remove deletes nothing
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int N_RAND    = 1920;
	localparam int SEG_LEN   = 40;
	localparam int HOLD_AT   = 300;
	localparam int HOLD_LEN  = 300;
	localparam int QUIET_LO  = 6000;
	localparam int QUIET_HI  = 12000;
	localparam int IDLE_MAX  = 5000;
	localparam int DRAIN_CYC = 40;
	localparam int MAX_PRINT = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	swsf_stream_if #(.T(req_t)) in_ch ();
	swsf_stream_if #(.T(rsp_t)) out_ch ();

	stack_with_search_and_filter_core #(.DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	// predicted store: stk_mem[0] is the oldest entry, stk_mem[stk_cnt-1] the front
	logic signed [VAL_W-1:0] stk_mem [DEPTH];
	int unsigned stk_cnt = 0;

	req_t req_q [$];
	rsp_t rsp_exp_q [$];
	logic signed [VAL_W-1:0] val_pool [8];

	int n_total = 0;
	int n_in = 0;
	int n_out = 0;
	int n_err = 0;
	int cyc = 0;
	int idle_cyc = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	logic in_fired = 1'b0;

	function automatic bit drops(logic signed [VAL_W-1:0] e, logic signed [VAL_W-1:0] v,
			logic [1:0] m);
		case (m)
			MODE_LT: return e < v;
			MODE_EQ: return e == v;
			MODE_GT: return e > v;
			default: return 1'b0;
		endcase
	endfunction

	function automatic rsp_t stack_apply(req_t r);
		rsp_t o;
		int unsigned kept;
		logic signed [VAL_W-1:0] v;
		o = '0;
		kept = 0;
		v = $signed(r.operand_value);
		case (cmd_t'(r.command))
			CMD_PUSH: begin
				if (stk_cnt >= DEPTH) o.status = STAT_PUSH_FULL;
				else begin
					stk_mem[stk_cnt] = v;
					stk_cnt++;
				end
			end
			CMD_POP: begin
				if (stk_cnt == 0) o.status = STAT_POP_EMPTY;
				else begin
					stk_cnt--;
					o.popped_value = stk_mem[stk_cnt];
				end
			end
			CMD_EXISTS: begin
				for (int i = 0; i < stk_cnt; i++)
					if (stk_mem[i] == v) o.found = 1'b1;
			end
			default: begin
				// keep survivors in order, compacted toward the back
				for (int i = 0; i < stk_cnt; i++) begin
					if (!drops(stk_mem[i], v, r.compare_mode)) begin
						stk_mem[kept] = stk_mem[i];
						kept++;
					end
				end
				stk_cnt = kept;
			end
		endcase
		o.entry_count = stk_cnt[CNT_OUT_W-1:0];
		o.is_empty = (stk_cnt == 0);
		return o;
	endfunction

	function automatic void queue_req(cmd_t c, logic [VAL_W-1:0] v, logic [1:0] m);
		req_t r;
		r.command = c;
		r.operand_value = v;
		r.compare_mode = m;
		req_q.push_back(r);
		n_total++;
	endfunction

	// mostly values from a small pool so that searches and removes hit
	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 60) return val_pool[3'($urandom_range(0, 7))];
		return $urandom;
	endfunction

	function automatic bit idle_now();
		if (cyc >= QUIET_LO && cyc < QUIET_HI) return 1'b0;
		return $urandom_range(0, 99) < 8;
	endfunction

	task automatic wait_drained();
		do @(negedge clk); while (n_in != n_total || rsp_exp_q.size() != 0);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			n_err++;
			if (n_err <= MAX_PRINT)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// request side: acceptance bookkeeping and prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fired <= 1'b0;
		end else begin
			in_fired <= in_ch.valid && in_ch.ready;
			cyc <= cyc + 1;
			if (in_ch.valid && in_ch.ready) begin
				rsp_exp_q.push_back(stack_apply(in_ch.data));
				n_in <= n_in + 1;
			end
		end
	end

	// request side: drive the next request at the falling edge
	always @(negedge clk) begin : drive_req
		logic nxt_v;
		req_t nxt_d;
		nxt_v = in_ch.valid;
		nxt_d = in_ch.data;
		if (!arst_n) begin
			nxt_v = 1'b0;
		end else if (!in_ch.valid || in_fired) begin
			nxt_v = 1'b0;
			if (!idle_now() && req_q.size() > 0) begin
				nxt_d = req_q.pop_front();
				nxt_v = 1'b1;
			end
		end
		in_ch.valid <= nxt_v;
		in_ch.data <= nxt_d;
	end

	// response side: compare with the oldest prediction
	always @(posedge clk) begin : check_rsp
		rsp_t want;
		rsp_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (rsp_exp_q.size() == 0) begin
				n_err++;
				if (n_err <= MAX_PRINT)
					$display("%0t: unexpected response, expected none, actual %h", $time, got);
			end else begin
				want = rsp_exp_q.pop_front();
				check_field("popped_value", want.popped_value, got.popped_value);
				check_field("found", 32'(want.found), 32'(got.found));
				check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
				check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
				check_field("status", 32'(want.status), 32'(got.status));
			end
			n_out <= n_out + 1;
		end
	end

	// response side: random stalls plus one long hold-off to back up the input
	always @(negedge clk) begin : drive_ready
		logic nxt_r;
		if (!arst_n) begin
			nxt_r = 1'b0;
		end else begin
			if (!hold_done && n_out >= HOLD_AT) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt_r = 1'b0;
			end else begin
				nxt_r = !idle_now();
			end
		end
		out_ch.ready <= nxt_r;
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cyc = 0;
		else idle_cyc++;
		if (idle_cyc >= IDLE_MAX) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int bias;
		int roll;
		cmd_t c;
		val_pool[0] = 32'sh8000_0000;
		val_pool[1] = 32'sh7fff_ffff;
		val_pool[2] = '0;
		val_pool[3] = -32'sd1;
		for (int i = 4; i < 8; i++) val_pool[i] = $urandom;

		// empty-store corner cases
		queue_req(CMD_POP, 32'd0, MODE_LT);
		queue_req(CMD_EXISTS, 32'd0, MODE_LT);
		queue_req(CMD_REMOVE, 32'd0, MODE_GT);
		// extremes, search hit and miss, remove with no rule and with equality
		queue_req(CMD_PUSH, 32'h7fff_ffff, MODE_NONE);
		queue_req(CMD_PUSH, 32'h8000_0000, MODE_EQ);
		queue_req(CMD_PUSH, 32'h0000_0000, MODE_LT);
		queue_req(CMD_PUSH, 32'hffff_ffff, MODE_GT);
		queue_req(CMD_EXISTS, 32'h8000_0000, MODE_LT);
		queue_req(CMD_EXISTS, 32'h0000_0001, MODE_NONE);
		queue_req(CMD_REMOVE, 32'h0000_0000, MODE_NONE);
		queue_req(CMD_REMOVE, 32'h0000_0000, MODE_EQ);
		// fill up, then one push into the full store
		for (int i = 0; i < DEPTH - 3; i++) queue_req(CMD_PUSH, pick_value(), MODE_LT);
		queue_req(CMD_PUSH, 32'h1234_5678, MODE_LT);
		queue_req(CMD_REMOVE, 32'hffff_ffff, MODE_GT);
		queue_req(CMD_REMOVE, 32'hffff_ffff, MODE_LT);
		queue_req(CMD_POP, 32'hffff_ffff, MODE_EQ);

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender pauses here until every response is back
		wait_drained();

		for (int s = 0; s < N_RAND / SEG_LEN; s++) begin
			bias = $urandom_range(0, 2);
			for (int i = 4; i < 8; i++)
				val_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 16) - 8;
			for (int k = 0; k < SEG_LEN; k++) begin
				roll = $urandom_range(0, 99);
				case (bias)
					0: c = (roll < 75) ? CMD_PUSH : (roll < 80) ? CMD_POP :
						(roll < 92) ? CMD_EXISTS : CMD_REMOVE;
					1: c = (roll < 15) ? CMD_PUSH : (roll < 75) ? CMD_POP :
						(roll < 85) ? CMD_EXISTS : CMD_REMOVE;
					default: c = (roll < 35) ? CMD_PUSH : (roll < 60) ? CMD_POP :
						(roll < 80) ? CMD_EXISTS : CMD_REMOVE;
				endcase
				queue_req(c, pick_value(), 2'($urandom_range(0, 3)));
			end
		end

		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		if (n_err == 0 && rsp_exp_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[filelist.f]
design/swsf_pkg.sv
design/swsf_stream_if.sv
design/swsf_mem.sv
design/swsf_ctrl.sv
design/stack_with_search_and_filter_core.sv
tb/stack_with_search_and_filter_core_tb.sv
